// ===== rtl/dll_pkg.sv =====
package dll_pkg;

  localparam int NODES = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W = $clog2(NODES);
  localparam int PTR_W = IDX_W + 1;
  localparam int CNT_W = PTR_W;
  localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

  localparam logic [3:0] OP_INS_FRONT  = 4'd0;
  localparam logic [3:0] OP_INS_BACK   = 4'd1;
  localparam logic [3:0] OP_INS_AFTER  = 4'd2;
  localparam logic [3:0] OP_INS_BEFORE = 4'd3;
  localparam logic [3:0] OP_PEEK_FRONT = 4'd4;
  localparam logic [3:0] OP_PEEK_BACK  = 4'd5;
  localparam logic [3:0] OP_POP_FRONT  = 4'd6;
  localparam logic [3:0] OP_POP_BACK   = 4'd7;
  localparam logic [3:0] OP_REMOVE     = 4'd8;
  localparam logic [3:0] OP_CONTAINS   = 4'd9;
  localparam logic [3:0] OP_COUNT      = 4'd10;
  localparam logic [3:0] OP_REVERSE    = 4'd11;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [3:0] DC_NONE     = 4'd0;
  localparam logic [3:0] DC_LATCH    = 4'd1;
  localparam logic [3:0] DC_RD_CUR   = 4'd2;
  localparam logic [3:0] DC_CMP      = 4'd3;
  localparam logic [3:0] DC_ALLOC    = 4'd4;
  localparam logic [3:0] DC_LINK_N   = 4'd5;
  localparam logic [3:0] DC_LINK_A   = 4'd6;
  localparam logic [3:0] DC_LINK_B   = 4'd7;
  localparam logic [3:0] DC_UNLINK_P = 4'd8;
  localparam logic [3:0] DC_UNLINK_Q = 4'd9;
  localparam logic [3:0] DC_FREE     = 4'd10;
  localparam logic [3:0] DC_REV_SWAP = 4'd11;
  localparam logic [3:0] DC_REV_END  = 4'd12;
  localparam logic [3:0] DC_DONE     = 4'd13;
  localparam logic [3:0] DC_RD_END   = 4'd14;

  typedef struct packed {
    logic [3:0] code;
  } dll_cmd_t;

  typedef struct packed {
    logic [3:0]       op;
    logic             no_nodes;
    logic             can_grab;
    logic             step_end;
    logic             match;
    logic             at_found;
  } dll_stat_t;

endpackage

// ===== rtl/dll_ram.sv =====
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/dll_datapath.sv =====
module dll_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dll_pkg::dll_cmd_t            cmd,
  input  logic [3:0]                   in_opcode,
  input  logic signed [31:0]           in_key,
  input  logic signed [31:0]           in_value,
  output dll_pkg::dll_stat_t           stat,
  output logic [1:0]                   res_status,
  output logic signed [31:0]           res_data,
  output logic                         res_found,
  output logic [6:0]                   res_count,
  output logic [6:0]                   res_length
);
  import dll_pkg::*;

  logic [3:0] op_r;
  logic [DATA_WIDTH-1:0] key_r, val_r;
  logic [PTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [PTR_W-1:0] fresh_r, fresh_nxt, cnt_r, cnt_nxt;
  logic [PTR_W-1:0] cur_r, cur_nxt, at_r, at_nxt, n_r, n_nxt;
  logic [PTR_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt, match_r, match_nxt;
  logic at_found_r, at_found_nxt;
  logic [1:0] status_r, status_nxt;
  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic found_r, found_nxt;

  logic v_we, nx_we, pv_we;
  logic [IDX_W-1:0] v_wa, nx_wa, pv_wa, rd_a;
  logic [DATA_WIDTH-1:0] v_wd, v_rd;
  logic [PTR_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

  dll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NODES)) u_val (
    .clk, .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(rd_a), .rdata(v_rd));
  dll_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_nxt (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_a), .rdata(nx_rd));
  dll_ram #(.WIDTH(PTR_W), .DEPTH(NODES)) u_prv (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_a), .rdata(pv_rd));

  logic [PTR_W-1:0] a_w, b_w, grab_n;

  always_comb begin
    if (op_r == OP_INS_FRONT) begin
      a_w = NIL; b_w = head_r;
    end else if (op_r == OP_INS_BACK) begin
      a_w = tail_r; b_w = NIL;
    end else if (op_r == OP_INS_AFTER) begin
      a_w = at_r; b_w = q_r;
    end else begin
      a_w = p_r; b_w = at_r;
    end
    grab_n = (free_r != NIL) ? free_r : fresh_r;
  end

  assign stat.op = op_r;
  assign stat.no_nodes = (head_r == NIL);
  assign stat.can_grab = (free_r != NIL) || (fresh_r != NIL);
  assign stat.step_end = (cur_r == NIL) || (steps_r == CNT_W'(NODES));
  assign stat.match = (v_rd == key_r);
  assign stat.at_found = at_found_r;

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; free_nxt = free_r;
    fresh_nxt = fresh_r; cnt_nxt = cnt_r; cur_nxt = cur_r;
    at_nxt = at_r; n_nxt = n_r; p_nxt = p_r; q_nxt = q_r;
    steps_nxt = steps_r; match_nxt = match_r; at_found_nxt = at_found_r;
    status_nxt = status_r; data_nxt = data_r; found_nxt = found_r;
    v_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
    v_wa = '0; nx_wa = '0; pv_wa = '0;
    v_wd = val_r; nx_wd = '0; pv_wd = '0;
    rd_a = cur_r[IDX_W-1:0];
    case (cmd.code)
      DC_LATCH: begin
        status_nxt = ST_OK; data_nxt = '0; found_nxt = 1'b0;
        match_nxt = '0; steps_nxt = '0; at_found_nxt = 1'b0;
        if (in_opcode == OP_PEEK_BACK || in_opcode == OP_POP_BACK) cur_nxt = tail_r;
        else cur_nxt = head_r;
        at_nxt = NIL;
      end
      DC_RD_CUR: ;
      DC_CMP: begin
        if (v_rd == key_r) begin
          at_found_nxt = 1'b1; at_nxt = cur_r; p_nxt = pv_rd; q_nxt = nx_rd;
          match_nxt = match_r + 1'b1;
        end
        cur_nxt = nx_rd;
        steps_nxt = steps_r + 1'b1;
      end
      DC_RD_END: begin
        n_nxt = cur_r; p_nxt = pv_rd; q_nxt = nx_rd;
        data_nxt = v_rd;
      end
      DC_ALLOC: begin
        n_nxt = grab_n;
        if (free_r != NIL) begin
          rd_a = free_r[IDX_W-1:0];
        end else begin
          fresh_nxt = fresh_r + 1'b1;
        end
      end
      DC_LINK_N: begin
        if (free_r == n_r) free_nxt = nx_rd;
        v_we = 1'b1; v_wa = n_r[IDX_W-1:0];
        nx_we = 1'b1; nx_wa = n_r[IDX_W-1:0]; nx_wd = b_w;
        pv_we = 1'b1; pv_wa = n_r[IDX_W-1:0]; pv_wd = a_w;
        cnt_nxt = cnt_r + 1'b1;
      end
      DC_LINK_A: begin
        if (a_w != NIL) begin
          nx_we = 1'b1; nx_wa = a_w[IDX_W-1:0]; nx_wd = n_r;
        end else head_nxt = n_r;
        if (b_w != NIL) begin
          pv_we = 1'b1; pv_wa = b_w[IDX_W-1:0]; pv_wd = n_r;
        end else tail_nxt = n_r;
      end
      DC_UNLINK_P: begin
        if (p_r != NIL) begin
          nx_we = 1'b1; nx_wa = p_r[IDX_W-1:0]; nx_wd = q_r;
        end else head_nxt = q_r;
        if (q_r != NIL) begin
          pv_we = 1'b1; pv_wa = q_r[IDX_W-1:0]; pv_wd = p_r;
        end else tail_nxt = p_r;
      end
      DC_FREE: begin
        nx_we = 1'b1; nx_wa = n_r[IDX_W-1:0]; nx_wd = free_r;
        free_nxt = n_r;
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
      end
      DC_REV_SWAP: begin
        nx_we = 1'b1; nx_wa = cur_r[IDX_W-1:0]; nx_wd = pv_rd;
        pv_we = 1'b1; pv_wa = cur_r[IDX_W-1:0]; pv_wd = nx_rd;
        cur_nxt = nx_rd;
        steps_nxt = steps_r + 1'b1;
      end
      DC_REV_END: begin
        head_nxt = tail_r; tail_nxt = head_r;
      end
      DC_UNLINK_Q: begin
        n_nxt = at_r;
        p_nxt = p_r; q_nxt = q_r;
      end
      DC_LINK_B: status_nxt = ST_NOTFOUND;
      DC_DONE: begin
        if (op_r == OP_CONTAINS) found_nxt = at_found_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; free_r <= NIL; fresh_r <= '0; cnt_r <= '0;
    end else begin
      head_r <= head_nxt; tail_r <= tail_nxt; free_r <= free_nxt;
      fresh_r <= fresh_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.code == DC_LATCH) begin
      op_r <= in_opcode;
      key_r <= DATA_WIDTH'(in_key);
      val_r <= DATA_WIDTH'(in_value);
    end
    cur_r <= cur_nxt; at_r <= at_nxt; n_r <= n_nxt; p_r <= p_nxt; q_r <= q_nxt;
    steps_r <= steps_nxt; match_r <= match_nxt; at_found_r <= at_found_nxt;
    status_r <= status_nxt; data_r <= data_nxt; found_r <= found_nxt;
  end

  assign res_status = status_r;
  assign res_data = 32'(signed'(data_r));
  assign res_found = found_r;
  assign res_count = (op_r == OP_COUNT) ? 7'(match_r) : 7'd0;
  assign res_length = 7'(cnt_r);
endmodule

// ===== rtl/dll_ctrl.sv =====
module dll_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dll_pkg::dll_stat_t stat,
  output dll_pkg::dll_cmd_t  cmd,
  output logic               set_status,
  output logic [1:0]         new_status,
  output logic               done
);
  import dll_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_SRD = 4'd2, S_SCMP = 4'd3,
    S_SDEC = 4'd4, S_ALLOC = 4'd5, S_LN = 4'd6, S_LA = 4'd7, S_ERD = 4'd8,
    S_EGET = 4'd9, S_UNL = 4'd10, S_FREE = 4'd11, S_RRD = 4'd12, S_RSW = 4'd13,
    S_OUT = 4'd14, S_ARD = 4'd15;

  logic [3:0] st_r, st_nxt;
  logic done_nxt, done_r;
  logic [1:0] ns;
  logic setst;

  always_comb begin
    st_nxt = st_r; cmd.code = DC_NONE; done_nxt = 1'b0; setst = 1'b0; ns = ST_OK;
    case (st_r)
      S_IDLE: if (start && !done_r) begin
        cmd.code = DC_LATCH; st_nxt = S_DISP;
      end
      S_DISP: begin
        case (stat.op)
          OP_INS_FRONT, OP_INS_BACK: st_nxt = S_ALLOC;
          OP_INS_AFTER, OP_INS_BEFORE, OP_REMOVE, OP_CONTAINS, OP_COUNT:
            st_nxt = S_SRD;
          OP_PEEK_FRONT, OP_PEEK_BACK, OP_POP_FRONT, OP_POP_BACK:
            if (stat.no_nodes) begin
              setst = 1'b1; ns = ST_EMPTY; st_nxt = S_OUT;
            end else st_nxt = S_ERD;
          OP_REVERSE: st_nxt = S_RRD;
          default: st_nxt = S_OUT;
        endcase
      end
      S_SRD: if (stat.step_end) st_nxt = S_SDEC;
             else st_nxt = S_SCMP;
      S_SCMP: begin
        cmd.code = DC_CMP;
        if (stat.match && stat.op != OP_COUNT) st_nxt = S_SDEC;
        else st_nxt = S_SRD;
      end
      S_SDEC: begin
        if (stat.op == OP_CONTAINS || stat.op == OP_COUNT) begin
          cmd.code = DC_DONE; st_nxt = S_OUT;
        end else if (!stat.at_found) begin
          setst = 1'b1; ns = ST_NOTFOUND; st_nxt = S_OUT;
        end else if (stat.op == OP_REMOVE) begin
          cmd.code = DC_UNLINK_Q; st_nxt = S_UNL;
        end else st_nxt = S_ALLOC;
      end
      S_ALLOC: if (stat.can_grab) begin
        cmd.code = DC_ALLOC; st_nxt = S_ARD;
      end else begin
        setst = 1'b1; ns = ST_FULL; st_nxt = S_OUT;
      end
      S_ARD: begin cmd.code = DC_LINK_N; st_nxt = S_LA; end
      S_LA: begin cmd.code = DC_LINK_A; st_nxt = S_OUT; end
      S_ERD: st_nxt = S_EGET;
      S_EGET: begin
        cmd.code = DC_RD_END;
        if (stat.op >= OP_POP_FRONT) st_nxt = S_UNL;
        else st_nxt = S_OUT;
      end
      S_UNL: begin cmd.code = DC_UNLINK_P; st_nxt = S_FREE; end
      S_FREE: begin cmd.code = DC_FREE; st_nxt = S_OUT; end
      S_RRD: if (stat.step_end) begin
        cmd.code = DC_REV_END; st_nxt = S_OUT;
      end else st_nxt = S_RSW;
      S_RSW: begin cmd.code = DC_REV_SWAP; st_nxt = S_RRD; end
      S_OUT: begin done_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; done_r <= 1'b0;
    end else begin
      st_r <= st_nxt; done_r <= done_nxt;
    end
  end

  assign busy = (st_r != S_IDLE) || done_r;
  assign set_status = setst;
  assign new_status = ns;
  assign done = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("done held");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE && start && !done_r) |=> st_r == S_DISP)
    else $error("start lost");
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> st_r == S_IDLE)
    else $error("done outside idle");
endmodule

// ===== rtl/doubly_linked_list_engine_top.sv =====
// Channel | Ports                                          | Handshake
// in      | in_opcode, in_key, in_value                     | start & !busy
// out     | out_status, out_data_out, out_found,           | out_valid, one cycle
//         | out_match_count, out_length                    |
// One item at a time. Key search and count walk the list, reading then
// comparing each node; reverse walks it, reading then swapping each node's
// links. The list holds up to 64 nodes. busy stays high through the result
// cycle.
// Synchronous active-low reset empties the list at once; no clearing pass.
// The receiver cannot stall: each result shows for one cycle with out_valid.
module doubly_linked_list_engine_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data_out,
  output logic               out_found,
  output logic [6:0]         out_match_count,
  output logic [6:0]         out_length
);
  import dll_pkg::*;

  dll_cmd_t cmd;
  dll_stat_t stat;
  logic set_status, done;
  logic [1:0] new_status, dp_status;
  logic [1:0] ovr_r;
  logic ovr_v_r;

  dll_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .stat, .cmd,
    .set_status, .new_status, .done);

  dll_datapath u_dp (
    .clk, .rst_n, .cmd, .in_opcode, .in_key, .in_value, .stat,
    .res_status(dp_status), .res_data(out_data_out), .res_found(out_found),
    .res_count(out_match_count), .res_length(out_length));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_v_r <= 1'b0;
    end else if (cmd.code == DC_LATCH) begin
      ovr_v_r <= 1'b0;
    end else if (set_status) begin
      ovr_v_r <= 1'b1;
    end
    if (set_status) ovr_r <= new_status;
  end

  assign out_valid = done;
  assign out_status = ovr_v_r ? ovr_r : dp_status;
endmodule
